/* hw/rtl/mct_pkg.sv */
// shared types and constants of the mouse cursor tracker
package mct_pkg;

	// fixed field widths
	localparam int BYTE_W    = 8;
	localparam int COL_W     = 7;
	localparam int ROW_W     = 5;
	localparam int CFG_IDX_W = 8;

	// default screen geometry and home position of the cursor
	localparam int DEF_SCREEN_COLS = 80;
	localparam int DEF_SCREEN_ROWS = 25;
	localparam int RESET_COL       = 40;
	localparam int RESET_ROW       = 12;

	// status bit that marks auxiliary (mouse) data
	localparam int AUX_DATA_BIT = 5;

	// register defaults
	localparam logic [BYTE_W-1:0] RST_CURSOR_GLYPH = 8'd219;
	localparam logic [BYTE_W-1:0] RST_CURSOR_COLOR = 8'd15;
	localparam logic [BYTE_W-1:0] RST_BLANK_GLYPH  = 8'd32;
	localparam logic [BYTE_W-1:0] RST_BLANK_COLOR  = 8'd0;

	// configuration register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CURSOR_GLYPH = 8'd0,
		REG_CURSOR_COLOR = 8'd1,
		REG_BLANK_GLYPH  = 8'd2,
		REG_BLANK_COLOR  = 8'd3
	} reg_idx_t;

	// position of a byte inside a packet
	typedef enum logic [1:0] {
		PKT_BUTTONS = 2'd0,
		PKT_DX      = 2'd1,
		PKT_DY      = 2'd2
	} pkt_pos_t;

	// one movement taken from a complete packet
	typedef struct packed {
		logic [BYTE_W-1:0] dx;
		logic [BYTE_W-1:0] dy;
	} move_t;

	// appearance of the two draw commands
	typedef struct packed {
		logic [BYTE_W-1:0] cursor_glyph;
		logic [BYTE_W-1:0] cursor_color;
		logic [BYTE_W-1:0] blank_glyph;
		logic [BYTE_W-1:0] blank_color;
	} look_t;

	// queue control between front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

/* hw/rtl/mct_if.sv */
// handshake channels of the mouse cursor tracker

// controller events in
interface mct_evt_if import mct_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] status_byte;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, status_byte, data_byte, input ready);
	modport sink   (input valid, status_byte, data_byte, output ready);
endinterface

// draw commands out
interface mct_cmd_if import mct_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [COL_W-1:0]  column;
	logic [ROW_W-1:0]  row;
	logic [BYTE_W-1:0] glyph;
	logic [BYTE_W-1:0] color;
	logic              last;

	modport source (output valid, column, row, glyph, color, last, input ready);
	modport sink   (input valid, column, row, glyph, color, last, output ready);
endinterface

// register writes
interface mct_cfg_if import mct_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [BYTE_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/mct_front.sv */
// front end: filters mouse bytes, assembles packets, queues movements
module mct_front import mct_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	mct_evt_if.sink    evt,
	input  q_stat_t    q_stat,
	output logic       push,
	output move_t      push_data
);

	logic [1:0]        byte_idx_q;
	logic [BYTE_W-1:0] dx_byte_q;
	logic              take;
	logic              is_aux;
	logic              at_dy;

	// a full queue holds off every event so ordering is kept simple
	assign evt.ready = !q_stat.full;
	assign take      = evt.valid && evt.ready;
	assign is_aux    = evt.status_byte[AUX_DATA_BIT];
	assign at_dy     = (byte_idx_q == PKT_DY);

	// movement leaves when the third byte lands and something moved
	assign push_data.dx = dx_byte_q;
	assign push_data.dy = evt.data_byte;
	assign push = take && is_aux && at_dy && ((dx_byte_q | evt.data_byte) != '0);

	// packet byte index, wraps after the third byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= PKT_BUTTONS;
		end else if (take && is_aux) begin
			unique case (byte_idx_q)
				PKT_BUTTONS: byte_idx_q <= PKT_DX;
				PKT_DX:      byte_idx_q <= PKT_DY;
				default:     byte_idx_q <= PKT_BUTTONS;
			endcase
		end
	end

	// x delta byte waits for the rest of the packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dx_byte_q <= '0;
		end else if (take && is_aux && (byte_idx_q == PKT_DX)) begin
			dx_byte_q <= evt.data_byte;
		end
	end

endmodule

/* hw/rtl/mct_queue.sv */
// two-entry movement queue between front and back
module mct_queue import mct_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  move_t   push_data,
	input  logic    pop,
	output move_t   pop_data,
	output q_stat_t stat
);

	localparam int DEPTH = 2;

	move_t      mem_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign stat.full  = (count_q == 2'(DEPTH));
	assign stat.empty = (count_q == 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hw/rtl/mct_back.sv */
// back end: moves the cursor and issues erase and draw commands
module mct_back import mct_pkg::*; #(
	parameter int SCREEN_COLS = DEF_SCREEN_COLS,
	parameter int SCREEN_ROWS = DEF_SCREEN_ROWS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  q_stat_t   q_stat,
	input  move_t     move,
	output logic      pop,
	input  look_t     look,
	mct_cmd_if.source cmd
);

	localparam int SUM_W   = 10;
	localparam int RST_COL = (RESET_COL > SCREEN_COLS - 1) ? SCREEN_COLS - 1 : RESET_COL;
	localparam int RST_ROW = (RESET_ROW > SCREEN_ROWS - 1) ? SCREEN_ROWS - 1 : RESET_ROW;
	localparam logic signed [SUM_W-1:0] COL_HI = SUM_W'(SCREEN_COLS - 1);
	localparam logic signed [SUM_W-1:0] ROW_HI = SUM_W'(SCREEN_ROWS - 1);

	logic [COL_W-1:0]        cursor_col_q;
	logic [ROW_W-1:0]        cursor_row_q;
	logic                    draw_pend_q;
	logic                    cmd_valid_q;
	logic [COL_W-1:0]        cmd_col_q;
	logic [ROW_W-1:0]        cmd_row_q;
	logic [BYTE_W-1:0]       cmd_glyph_q;
	logic [BYTE_W-1:0]       cmd_color_q;
	logic                    cmd_last_q;
	logic                    out_free;
	logic                    load_draw;
	logic signed [SUM_W-1:0] col_sum;
	logic signed [SUM_W-1:0] row_sum;
	logic [COL_W-1:0]        new_col;
	logic [ROW_W-1:0]        new_row;

	// output register frees when empty or taken this cycle
	assign out_free  = !cmd_valid_q || cmd.ready;
	assign pop       = !q_stat.empty && !draw_pend_q && out_free;
	assign load_draw = draw_pend_q && out_free;

	// add deltas (y inverted) and clamp to the screen
	always_comb begin
		col_sum = signed'({3'b000, cursor_col_q}) + signed'({{2{move.dx[7]}}, move.dx});
		row_sum = signed'({5'b00000, cursor_row_q}) - signed'({{2{move.dy[7]}}, move.dy});
		if (col_sum < 0) begin
			new_col = '0;
		end else if (col_sum > COL_HI) begin
			new_col = COL_HI[COL_W-1:0];
		end else begin
			new_col = col_sum[COL_W-1:0];
		end
		if (row_sum < 0) begin
			new_row = '0;
		end else if (row_sum > ROW_HI) begin
			new_row = ROW_HI[ROW_W-1:0];
		end else begin
			new_row = row_sum[ROW_W-1:0];
		end
	end

	// cursor position, pending draw and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q <= COL_W'(RST_COL);
			cursor_row_q <= ROW_W'(RST_ROW);
			draw_pend_q  <= 1'b0;
			cmd_valid_q  <= 1'b0;
		end else if (pop) begin
			cursor_col_q <= new_col;
			cursor_row_q <= new_row;
			draw_pend_q  <= 1'b1;
			cmd_valid_q  <= 1'b1;
		end else if (load_draw) begin
			draw_pend_q  <= 1'b0;
			cmd_valid_q  <= 1'b1;
		end else if (out_free) begin
			cmd_valid_q  <= 1'b0;
		end
	end

	// command payload: erase at the old cell, then draw at the new one
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_col_q   <= cursor_col_q;
			cmd_row_q   <= cursor_row_q;
			cmd_glyph_q <= look.blank_glyph;
			cmd_color_q <= look.blank_color;
			cmd_last_q  <= 1'b0;
		end else if (load_draw) begin
			cmd_col_q   <= cursor_col_q;
			cmd_row_q   <= cursor_row_q;
			cmd_glyph_q <= look.cursor_glyph;
			cmd_color_q <= look.cursor_color;
			cmd_last_q  <= 1'b1;
		end
	end

	assign cmd.valid  = cmd_valid_q;
	assign cmd.column = cmd_col_q;
	assign cmd.row    = cmd_row_q;
	assign cmd.glyph  = cmd_glyph_q;
	assign cmd.color  = cmd_color_q;
	assign cmd.last   = cmd_last_q;

endmodule

/* hw/rtl/ps2_mouse_cursor_tracker_unit.sv */
// PS/2 mouse cursor tracker: event intake, movement queue, cursor update and draw output.
// The unit takes one controller event per cycle; events without the auxiliary-data status
// bit are dropped, mouse bytes fill a three-byte packet, and each packet with a nonzero
// movement byte moves a text cursor clamped to SCREEN_COLS x SCREEN_ROWS. Such a packet
// yields two draw commands on consecutive cycles when the sink is ready: the erase at the
// old cell (last=0), then the cursor glyph at the new cell (last=1). The movement from the
// third packet byte is queued, then popped into the registered erase command. A two-entry
// movement queue sits between intake and cursor logic; events stall only when it holds two
// unserved packets. Register writes are always accepted and are meant for idle periods.
module ps2_mouse_cursor_tracker_unit import mct_pkg::*; #(
	parameter int SCREEN_COLS = DEF_SCREEN_COLS,
	parameter int SCREEN_ROWS = DEF_SCREEN_ROWS
) (
	input  logic      clk,
	input  logic      arst_n,
	mct_evt_if.sink   evt,
	mct_cfg_if.sink   cfg,
	mct_cmd_if.source cmd
);

	look_t   look_q;
	q_stat_t q_stat;
	logic    push;
	move_t   push_data;
	logic    pop;
	move_t   pop_data;

	// register writes always complete at once
	assign cfg.ready = 1'b1;

	// configuration registers, writes beyond the map are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			look_q.cursor_glyph <= RST_CURSOR_GLYPH;
			look_q.cursor_color <= RST_CURSOR_COLOR;
			look_q.blank_glyph  <= RST_BLANK_GLYPH;
			look_q.blank_color  <= RST_BLANK_COLOR;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_CURSOR_GLYPH: look_q.cursor_glyph <= cfg.data;
				REG_CURSOR_COLOR: look_q.cursor_color <= cfg.data;
				REG_BLANK_GLYPH:  look_q.blank_glyph  <= cfg.data;
				REG_BLANK_COLOR:  look_q.blank_color  <= cfg.data;
				default:          look_q <= look_q;
			endcase
		end
	end

	mct_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	mct_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	mct_back #(
		.SCREEN_COLS (SCREEN_COLS),
		.SCREEN_ROWS (SCREEN_ROWS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.move   (pop_data),
		.pop    (pop),
		.look   (look_q),
		.cmd    (cmd)
	);

endmodule

/* hw/rtl/mct_checker.sv */
// port-level checks of the cursor tracker and their binding
module mct_checker import mct_pkg::*; #(
	parameter int SCREEN_COLS = DEF_SCREEN_COLS,
	parameter int SCREEN_ROWS = DEF_SCREEN_ROWS
) (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input logic [COL_W-1:0]  cmd_column,
	input logic [ROW_W-1:0]  cmd_row,
	input logic [BYTE_W-1:0] cmd_glyph,
	input logic [BYTE_W-1:0] cmd_color,
	input logic              cmd_last,
	input logic              cfg_valid,
	input logic              cfg_ready
);

	localparam logic [COL_W-1:0] COL_MAX = COL_W'(SCREEN_COLS - 1);
	localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(SCREEN_ROWS - 1);

	// a stalled command holds its payload
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_column) && $stable(cmd_row)
			&& $stable(cmd_glyph) && $stable(cmd_color) && $stable(cmd_last))
		else $error("draw command changed while stalled");

	// every erase transfer is followed at once by its cursor draw
	a_draw_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && !cmd_last |=> cmd_valid && cmd_last)
		else $error("erase not followed by cursor draw");

	// commands stay on screen
	a_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> cmd_column <= COL_MAX && cmd_row <= ROW_MAX)
		else $error("draw command off screen");

	// a draw transfer is never followed directly by another draw
	a_no_double_draw: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_last |=> !(cmd_valid && cmd_last))
		else $error("cursor draw without its erase");

	// register writes never stall
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write stalled");

endmodule

bind ps2_mouse_cursor_tracker_unit mct_checker #(
	.SCREEN_COLS (SCREEN_COLS),
	.SCREEN_ROWS (SCREEN_ROWS)
) u_mct_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.cmd_column (cmd.column),
	.cmd_row    (cmd.row),
	.cmd_glyph  (cmd.glyph),
	.cmd_color  (cmd.color),
	.cmd_last   (cmd.last),
	.cfg_valid  (cfg.valid),
	.cfg_ready  (cfg.ready)
);

/* test/ps2_mouse_cursor_tracker_unit_test.sv */
// self-checking testbench of the ps2 mouse cursor tracker unit
module ps2_mouse_cursor_tracker_unit_test import mct_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLS         = DEF_SCREEN_COLS;
	localparam int ROWS         = DEF_SCREEN_ROWS;
	localparam int NUM_REGS     = 4;
	localparam int DIR_ROWS     = 24;
	localparam int N_PHASES     = 5;
	localparam int PHASE_ITEMS  = 105;
	localparam int SETTLE       = 8;
	localparam int HOLD_CYCLES  = 200;
	localparam int STALL_LIMIT  = 5000;
	localparam int IDLE_PCT     = 32;
	localparam int MAX_REPORTS  = 10;
	localparam logic [BYTE_W-1:0] AUX_MASK = 8'(1 << AUX_DATA_BIT);

	// one draw command as seen on the output channel
	typedef struct packed {
		logic [COL_W-1:0]  column;
		logic [ROW_W-1:0]  row;
		logic [BYTE_W-1:0] glyph;
		logic [BYTE_W-1:0] color;
		logic              last;
	} draw_cmd_t;

	// per-event note: typed rows carry the erase and draw cells written out by hand
	typedef struct {
		bit typed;
		int n;
		int c0;
		int r0;
		int c1;
		int r1;
	} evt_tag_t;

	typedef struct {
		logic [BYTE_W-1:0] status;
		logic [BYTE_W-1:0] data;
		evt_tag_t          tag;
	} stim_row_t;

	// directed events: reset home is column 40, row 12
	stim_row_t dir_tab [DIR_ROWS] = '{
		// not mouse data
		'{8'h00, 8'hFF, '{1, 0, 0, 0, 0, 0}},
		'{8'hDF, 8'h55, '{1, 0, 0, 0, 0, 0}},
		// one step right from home
		'{8'h28, 8'h08, '{1, 0, 0, 0, 0, 0}},
		'{8'h20, 8'h01, '{1, 0, 0, 0, 0, 0}},
		'{8'h20, 8'h00, '{1, 2, 40, 12, 41, 12}},
		// packet without movement
		'{8'hFF, 8'hFF, '{1, 0, 0, 0, 0, 0}},
		'{8'h20, 8'h00, '{1, 0, 0, 0, 0, 0}},
		'{8'h20, 8'h00, '{1, 0, 0, 0, 0, 0}},
		// largest right and down, clamped at the far corner
		'{8'h21, 8'h00, '{1, 0, 0, 0, 0, 0}},
		'{8'h20, 8'h7F, '{1, 0, 0, 0, 0, 0}},
		'{8'h20, 8'h80, '{1, 2, 41, 12, 79, 24}},
		// largest left and up, clamped at the origin
		'{8'h20, 8'h07, '{1, 0, 0, 0, 0, 0}},
		'{8'h20, 8'h80, '{1, 0, 0, 0, 0, 0}},
		'{8'h20, 8'h7F, '{1, 2, 79, 24, 0, 0}},
		// push past the origin again
		'{8'h20, 8'hFF, '{1, 0, 0, 0, 0, 0}},
		'{8'h20, 8'hFF, '{1, 0, 0, 0, 0, 0}},
		'{8'h20, 8'h01, '{1, 2, 0, 0, 0, 0}},
		// a foreign event inside a packet
		'{8'h20, 8'h00, '{0, 0, 0, 0, 0, 0}},
		'{8'h01, 8'hAA, '{0, 0, 0, 0, 0, 0}},
		'{8'h20, 8'h01, '{0, 0, 0, 0, 0, 0}},
		'{8'hE0, 8'hFF, '{0, 0, 0, 0, 0, 0}},
		// vertical move only
		'{8'h20, 8'h00, '{0, 0, 0, 0, 0, 0}},
		'{8'h20, 8'h00, '{0, 0, 0, 0, 0, 0}},
		'{8'h20, 8'hFE, '{0, 0, 0, 0, 0, 0}}
	};

	logic clk;
	logic arst_n;

	mct_evt_if evt_ch ();
	mct_cfg_if cfg_ch ();
	mct_cmd_if cmd_ch ();

	ps2_mouse_cursor_tracker_unit #(
		.SCREEN_COLS(COLS),
		.SCREEN_ROWS(ROWS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt_ch),
		.cfg(cfg_ch),
		.cmd(cmd_ch)
	);

	// tracker state mirrored by the testbench
	look_t             cur_look = '{RST_CURSOR_GLYPH, RST_CURSOR_COLOR,
	                                RST_BLANK_GLYPH, RST_BLANK_COLOR};
	pkt_pos_t          pkt_idx  = PKT_BUTTONS;
	logic [BYTE_W-1:0] pkt_bytes [3] = '{8'h00, 8'h00, 8'h00};
	int                cur_col  = (RESET_COL > COLS - 1) ? COLS - 1 : RESET_COL;
	int                cur_row  = (RESET_ROW > ROWS - 1) ? ROWS - 1 : RESET_ROW;

	draw_cmd_t draw_q [$];
	evt_tag_t  evt_tag_q [$];

	int  errors       = 0;
	int  reports      = 0;
	int  stall_cycles = 0;
	int  n_events     = 0;
	int  n_moves      = 0;
	int  n_checked    = 0;
	int  n_writes     = 0;
	bit  tx_idle_en   = 1;
	bit  rx_idle_en   = 1;
	bit  hold_req     = 0;

	function automatic int clamp_to(input int v, input int hi);
		if (v > hi)
			v = hi;
		if (v < 0)
			v = 0;
		return v;
	endfunction

	// packet assembly and cursor move for one controller event
	function automatic int decode_mouse_event(input logic [BYTE_W-1:0] st,
			input logic [BYTE_W-1:0] dat, output draw_cmd_t erase, output draw_cmd_t paint);
		int dx;
		int dy;
		erase = '0;
		paint = '0;
		if ((st & AUX_MASK) == 0)
			return 0;
		pkt_bytes[pkt_idx] = dat;
		case (pkt_idx)
			PKT_BUTTONS: pkt_idx = PKT_DX;
			PKT_DX:      pkt_idx = PKT_DY;
			default:     pkt_idx = PKT_BUTTONS;
		endcase
		if (pkt_idx != PKT_BUTTONS)
			return 0;
		if (pkt_bytes[PKT_DX] == 0 && pkt_bytes[PKT_DY] == 0)
			return 0;
		dx = $signed(pkt_bytes[PKT_DX]);
		dy = $signed(pkt_bytes[PKT_DY]);
		dy = -dy;
		erase = '{COL_W'(cur_col), ROW_W'(cur_row), cur_look.blank_glyph,
		          cur_look.blank_color, 1'b0};
		cur_col = clamp_to(cur_col + dx, COLS - 1);
		cur_row = clamp_to(cur_row + dy, ROWS - 1);
		paint = '{COL_W'(cur_col), ROW_W'(cur_row), cur_look.cursor_glyph,
		          cur_look.cursor_color, 1'b1};
		return 2;
	endfunction

	// movement byte: mostly small steps, some extremes, some full range
	function automatic logic [BYTE_W-1:0] pick_delta();
		int sel;
		int d;
		sel = $urandom_range(99);
		if (sel < 55) begin
			d = int'($urandom_range(12)) - 6;
			return BYTE_W'(d);
		end else if (sel < 70) begin
			case ($urandom_range(3))
				0: return 8'h7F;
				1: return 8'h80;
				2: return 8'h01;
				default: return 8'hFF;
			endcase
		end
		return BYTE_W'($urandom);
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// result sink with random stalls and one long hold-off on request
	initial begin : rx_side
		int hold_left;
		hold_left = 0;
		cmd_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				cmd_ch.ready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 0;
				hold_left = HOLD_CYCLES - 1;
				cmd_ch.ready <= 1'b0;
			end else begin
				cmd_ch.ready <= !(rx_idle_en && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// monitor: predict on event transfer, track register writes, check commands
	always @(posedge clk) begin : monitor
		draw_cmd_t got;
		draw_cmd_t want;
		draw_cmd_t er;
		draw_cmd_t pt;
		evt_tag_t  tag;
		int        n;
		bit        moved;
		moved = 0;
		if (cmd_ch.valid && cmd_ch.ready) begin
			moved = 1;
			got = '{cmd_ch.column, cmd_ch.row, cmd_ch.glyph, cmd_ch.color, cmd_ch.last};
			if (draw_q.size() == 0) begin
				errors++;
				if (reports < MAX_REPORTS) begin
					reports++;
					$display("unexpected draw command col %0d row %0d glyph %02h %s",
						got.column, got.row, got.glyph, "");
					$display("    color %02h last %0b", got.color, got.last);
				end
			end else begin
				want = draw_q.pop_front();
				n_checked++;
				if (got.column != want.column || got.row != want.row ||
						got.glyph != want.glyph || got.color != want.color ||
						got.last != want.last) begin
					errors++;
					if (reports < MAX_REPORTS) begin
						reports++;
						$display("draw mismatch: expected col %0d row %0d glyph %02h",
							want.column, want.row, want.glyph);
						$display("    color %02h last %0b", want.color, want.last);
						$display("               actual   col %0d row %0d glyph %02h",
							got.column, got.row, got.glyph);
						$display("    color %02h last %0b", got.color, got.last);
					end
				end
			end
		end
		if (evt_ch.valid && evt_ch.ready) begin
			moved = 1;
			n_events++;
			tag = '{0, 0, 0, 0, 0, 0};
			if (evt_tag_q.size() != 0)
				tag = evt_tag_q.pop_front();
			n = decode_mouse_event(evt_ch.status_byte, evt_ch.data_byte, er, pt);
			if (tag.typed) begin
				if (tag.n == 2) begin
					draw_q.push_back(draw_cmd_t'{COL_W'(tag.c0), ROW_W'(tag.r0),
					                 RST_BLANK_GLYPH, RST_BLANK_COLOR, 1'b0});
					draw_q.push_back(draw_cmd_t'{COL_W'(tag.c1), ROW_W'(tag.r1),
					                 RST_CURSOR_GLYPH, RST_CURSOR_COLOR, 1'b1});
				end
			end else if (n == 2) begin
				draw_q.push_back(er);
				draw_q.push_back(pt);
			end
			if (n == 2)
				n_moves++;
		end
		if (cfg_ch.valid && cfg_ch.ready) begin
			moved = 1;
			n_writes++;
			case (cfg_ch.index)
				REG_CURSOR_GLYPH: cur_look.cursor_glyph = cfg_ch.data;
				REG_CURSOR_COLOR: cur_look.cursor_color = cfg_ch.data;
				REG_BLANK_GLYPH:  cur_look.blank_glyph  = cfg_ch.data;
				REG_BLANK_COLOR:  cur_look.blank_color  = cfg_ch.data;
				default: ;
			endcase
		end
		if (moved)
			stall_cycles = 0;
		else
			stall_cycles++;
	end

	// watchdog on cycles without any transfer
	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
		$display("ps2_mouse_cursor_tracker_unit_test: FAIL");
		$finish;
	end

	// offer one event, with random gaps in front when enabled
	task automatic send_event(input logic [BYTE_W-1:0] st, input logic [BYTE_W-1:0] dat,
			input evt_tag_t tag);
		while (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
			evt_ch.valid <= 1'b0;
			@(posedge clk);
		end
		evt_tag_q.push_back(tag);
		evt_ch.valid       <= 1'b1;
		evt_ch.status_byte <= st;
		evt_ch.data_byte   <= dat;
		do
			@(posedge clk);
		while (!evt_ch.ready);
	endtask

	// one well-formed packet with random content, foreign events mixed in
	task automatic send_packet(inout int n_mouse);
		logic [BYTE_W-1:0] bytes [3];
		evt_tag_t          none;
		none = '{0, 0, 0, 0, 0, 0};
		bytes[0] = BYTE_W'($urandom);
		bytes[1] = pick_delta();
		bytes[2] = pick_delta();
		if ($urandom_range(99) < 8) begin
			bytes[1] = '0;
			bytes[2] = '0;
		end
		for (int k = 0; k < 3; k++) begin
			if ($urandom_range(99) < 10)
				send_event(BYTE_W'($urandom) & ~AUX_MASK, BYTE_W'($urandom), none);
			send_event(BYTE_W'($urandom) | AUX_MASK, bytes[k], none);
			n_mouse++;
		end
	endtask

	task automatic write_look_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [BYTE_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
	endtask

	// write all four registers plus one index past the map
	task automatic apply_look(input look_t lk);
		write_look_reg(REG_CURSOR_GLYPH, lk.cursor_glyph);
		write_look_reg(REG_CURSOR_COLOR, lk.cursor_color);
		write_look_reg(REG_BLANK_GLYPH, lk.blank_glyph);
		write_look_reg(REG_BLANK_COLOR, lk.blank_color);
		write_look_reg(CFG_IDX_W'($urandom_range(255, NUM_REGS)), BYTE_W'($urandom));
		cfg_ch.valid <= 1'b0;
	endtask

	// wait until every expected command has come, then let the pipeline settle
	task automatic drain();
		do
			@(posedge clk);
		while (draw_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// main sequence
	initial begin : main
		int    n_mouse;
		bit    pressure_done;
		look_t lk;
		arst_n             = 1'b0;
		evt_ch.valid       <= 1'b0;
		evt_ch.status_byte <= '0;
		evt_ch.data_byte   <= '0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= '0;
		cfg_ch.data        <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part at reset register values
		for (int i = 0; i < DIR_ROWS; i++)
			send_event(dir_tab[i].status, dir_tab[i].data, dir_tab[i].tag);
		evt_ch.valid <= 1'b0;
		drain();

		// random phases, one register setting each
		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: lk = '{8'h00, 8'h00, 8'h00, 8'h00};
				1: lk = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
				default: lk = look_t'($urandom);
			endcase
			apply_look(lk);
			// second phase runs without any idling
			tx_idle_en = (p != 1);
			rx_idle_en = (p != 1);
			n_mouse = 0;
			pressure_done = 0;
			while (n_mouse < PHASE_ITEMS) begin
				if (!pressure_done && n_mouse >= PHASE_ITEMS / 2) begin
					pressure_done = 1;
					if (p == 2) begin
						hold_req = 1;
					end else if (p == 3) begin
						evt_ch.valid <= 1'b0;
						drain();
					end
				end
				send_packet(n_mouse);
			end
			evt_ch.valid <= 1'b0;
			drain();
		end

		errors += draw_q.size();
		$display("run covered %0d events, %0d moving packets, %0d draw commands checked",
			n_events, n_moves, n_checked);
		$display("over %0d register writes, with stalls, a long sink hold-off and a drain pause",
			n_writes);
		if (errors == 0) begin
			$display("ps2_mouse_cursor_tracker_unit_test: PASS");
		end else begin
			$display("%0d failures", errors);
			$display("ps2_mouse_cursor_tracker_unit_test: FAIL");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/mct_pkg.sv
hw/rtl/mct_if.sv
hw/rtl/mct_front.sv
hw/rtl/mct_queue.sv
hw/rtl/mct_back.sv
hw/rtl/ps2_mouse_cursor_tracker_unit.sv
hw/rtl/mct_checker.sv
test/ps2_mouse_cursor_tracker_unit_test.sv
